// File: rtl/core/bps_pkg.sv
// Package for the beep pattern sequencer: command codes, field widths,
// default parameter values and the shared control flag type.
// No dependencies.
package bps_pkg;

    // Fixed widths of the request and result fields.
    localparam int CMD_W = 2;
    localparam int LEN_W = 16;
    localparam int CNT_W = 8;

    // Defaults for the core parameters.
    localparam int TIME_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 8;

    // Command codes carried by a request.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_BEEP    = 2'd1,
        CMD_PATTERN = 2'd2,
        CMD_STOP    = 2'd3
    } t_cmd;

    // Control flags of the sequencer.
    typedef struct packed {
        logic running;
        logic sounding;
        logic phase_is_on;
    } t_flags;

endpackage

// File: rtl/core/bps_if.sv
// Valid/ready channel interfaces for the beep pattern sequencer.
// Depends on bps_pkg for the field widths.
interface bps_cmd_if
    import bps_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [LEN_W-1:0] beep_length;
    logic [CNT_W-1:0] tone_count;
    logic [LEN_W-1:0] on_length;
    logic [LEN_W-1:0] off_length;

    modport source (output valid, command, beep_length, tone_count, on_length,
                    off_length, input ready);
    modport sink   (input valid, command, beep_length, tone_count, on_length,
                    off_length, output ready);
endinterface

interface bps_res_if;
    logic valid;
    logic ready;
    logic drive;
    logic busy_res;

    modport source (output valid, drive, busy_res, input ready);
    modport sink   (input valid, drive, busy_res, output ready);
endinterface

// File: rtl/core/bps_next.sv
// Next-state logic of the beep pattern sequencer for one request.
// Depends on bps_pkg for command codes and the flag struct.
module bps_next
    import bps_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_accept,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [LEN_W-1:0]      i_beep_length,
    input  logic [CNT_W-1:0]      i_tone_count,
    input  logic [LEN_W-1:0]      i_on_length,
    input  logic [LEN_W-1:0]      i_off_length,
    input  t_flags                i_flags,
    input  logic [COUNT_BITS-1:0] i_tones_total,
    input  logic [COUNT_BITS-1:0] i_tones_done,
    input  logic [TIME_BITS-1:0]  i_phase_ticks,
    input  logic [TIME_BITS-1:0]  i_on_held,
    input  logic [TIME_BITS-1:0]  i_off_held,
    output t_flags                o_flags,
    output logic [COUNT_BITS-1:0] o_tones_total,
    output logic [COUNT_BITS-1:0] o_tones_done,
    output logic [TIME_BITS-1:0]  o_phase_ticks,
    output logic [TIME_BITS-1:0]  o_on_held,
    output logic [TIME_BITS-1:0]  o_off_held
);

    localparam logic [TIME_BITS-1:0]  TIME_MAX  = {TIME_BITS{1'b1}};

    logic [TIME_BITS-1:0]  beep_len;
    logic [TIME_BITS-1:0]  on_len;
    logic [TIME_BITS-1:0]  off_len;
    logic [COUNT_BITS-1:0] count;
    logic [TIME_BITS-1:0]  ticks_inc;
    logic [COUNT_BITS-1:0] done_inc;

    // Fit the request lengths into the timer width, saturating when narrower.
    if (TIME_BITS >= LEN_W) begin : g_time_wide
        assign beep_len = TIME_BITS'(i_beep_length);
        assign on_len   = TIME_BITS'(i_on_length);
        assign off_len  = TIME_BITS'(i_off_length);
    end else begin : g_time_narrow
        assign beep_len = (i_beep_length > LEN_W'(TIME_MAX)) ? TIME_MAX
                                                             : i_beep_length[TIME_BITS-1:0];
        assign on_len   = (i_on_length > LEN_W'(TIME_MAX)) ? TIME_MAX
                                                           : i_on_length[TIME_BITS-1:0];
        assign off_len  = (i_off_length > LEN_W'(TIME_MAX)) ? TIME_MAX
                                                            : i_off_length[TIME_BITS-1:0];
    end

    // Fit the tone count into the counter width the same way.
    if (COUNT_BITS >= CNT_W) begin : g_count_wide
        assign count = COUNT_BITS'(i_tone_count);
    end else begin : g_count_narrow
        localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
        assign count = (i_tone_count > CNT_W'(COUNT_MAX)) ? COUNT_MAX
                                                          : i_tone_count[COUNT_BITS-1:0];
    end

    // Saturating phase tick count and the tone count after this gap.
    assign ticks_inc = (i_phase_ticks == TIME_MAX) ? i_phase_ticks
                                                   : i_phase_ticks + TIME_BITS'(1);
    assign done_inc  = i_tones_done + COUNT_BITS'(1);

    // Decode the command and work out the state after it.
    always_comb begin
        o_flags       = i_flags;
        o_tones_total = i_tones_total;
        o_tones_done  = i_tones_done;
        o_phase_ticks = i_phase_ticks;
        o_on_held     = i_on_held;
        o_off_held    = i_off_held;
        if (i_accept) begin
            unique case (t_cmd'(i_command)) inside
                CMD_TICK: begin
                    if (i_flags.running) begin
                        o_phase_ticks = ticks_inc;
                        if (i_tones_total == '0) begin
                            // Single beep: end once the on time has passed.
                            if (ticks_inc >= i_on_held) begin
                                o_flags.sounding = 1'b0;
                                o_flags.running  = 1'b0;
                            end
                        end else if (i_flags.phase_is_on) begin
                            if (ticks_inc >= i_on_held) begin
                                o_flags.sounding    = 1'b0;
                                o_flags.phase_is_on = 1'b0;
                                o_phase_ticks       = '0;
                            end
                        end else if (ticks_inc >= i_off_held) begin
                            // Gap done: finish the pattern or start the next tone.
                            o_tones_done = done_inc;
                            if (done_inc >= i_tones_total) begin
                                o_flags.running = 1'b0;
                            end else begin
                                o_flags.sounding    = 1'b1;
                                o_flags.phase_is_on = 1'b1;
                                o_phase_ticks       = '0;
                            end
                        end
                    end
                end
                CMD_BEEP, CMD_PATTERN: begin
                    o_tones_done        = '0;
                    o_phase_ticks       = '0;
                    o_flags.phase_is_on = 1'b1;
                    o_flags.sounding    = 1'b1;
                    o_flags.running     = 1'b1;
                    if (t_cmd'(i_command) == CMD_BEEP) begin
                        o_tones_total = '0;
                        o_on_held     = beep_len;
                    end else if (count == '0) begin
                        // An empty pattern is a zero-length beep.
                        o_tones_total = '0;
                        o_on_held     = '0;
                    end else begin
                        o_tones_total = count;
                        o_on_held     = on_len;
                        o_off_held    = off_len;
                    end
                end
                CMD_STOP: begin
                    o_flags.sounding = 1'b0;
                    o_flags.running  = 1'b0;
                end
                default: begin
                    o_flags = i_flags;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/beep_pattern_sequencer_core.sv
// Top level of the beep pattern sequencer: state registers and result register.
// Depends on bps_pkg, the channel interfaces in bps_if and bps_next.
//
// Usage:
// Requests arrive on i_cmd as commands: tick (one millisecond passes),
// single beep, pattern start and stop. Every accepted request yields
// exactly one result on o_res, carrying the buzzer drive level and the
// busy flag as they stand after that request.
// The result of a request accepted at one clock edge is registered and
// valid from the next edge on. Throughput is one request per cycle; the
// limit is the single result register, refilled in the cycle it is taken.
// While the receiver stalls with a result waiting, i_cmd.ready is low and
// the waiting result holds; when it is taken, a new request can be accepted
// at the same edge. Lengths and counts wider than TIME_BITS and COUNT_BITS
// saturate. Reset leaves the sequencer idle and silent with all counters
// and held lengths cleared and no result pending.
module beep_pattern_sequencer_core
    import bps_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bps_cmd_if.sink  i_cmd,
    bps_res_if.source o_res
);

    t_flags                r_flags;
    logic [COUNT_BITS-1:0] r_tones_total;
    logic [COUNT_BITS-1:0] r_tones_done;
    logic [TIME_BITS-1:0]  r_phase_ticks;
    logic [TIME_BITS-1:0]  r_on_held;
    logic [TIME_BITS-1:0]  r_off_held;

    t_flags                n_flags;
    logic [COUNT_BITS-1:0] n_tones_total;
    logic [COUNT_BITS-1:0] n_tones_done;
    logic [TIME_BITS-1:0]  n_phase_ticks;
    logic [TIME_BITS-1:0]  n_on_held;
    logic [TIME_BITS-1:0]  n_off_held;

    logic r_res_valid;
    logic r_drive;
    logic r_busy;
    logic accept;

    // A request is taken whenever the result register is free or being emptied.
    assign i_cmd.ready = !r_res_valid || o_res.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    bps_next #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_next (
        .i_accept      (accept),
        .i_command     (i_cmd.command),
        .i_beep_length (i_cmd.beep_length),
        .i_tone_count  (i_cmd.tone_count),
        .i_on_length   (i_cmd.on_length),
        .i_off_length  (i_cmd.off_length),
        .i_flags       (r_flags),
        .i_tones_total (r_tones_total),
        .i_tones_done  (r_tones_done),
        .i_phase_ticks (r_phase_ticks),
        .i_on_held     (r_on_held),
        .i_off_held    (r_off_held),
        .o_flags       (n_flags),
        .o_tones_total (n_tones_total),
        .o_tones_done  (n_tones_done),
        .o_phase_ticks (n_phase_ticks),
        .o_on_held     (n_on_held),
        .o_off_held    (n_off_held)
    );

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags       <= '0;
            r_tones_total <= '0;
            r_tones_done  <= '0;
            r_phase_ticks <= '0;
            r_on_held     <= '0;
            r_off_held    <= '0;
        end else begin
            r_flags       <= n_flags;
            r_tones_total <= n_tones_total;
            r_tones_done  <= n_tones_done;
            r_phase_ticks <= n_phase_ticks;
            r_on_held     <= n_on_held;
            r_off_held    <= n_off_held;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (accept) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // Result payload, loaded with the state after each accepted request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_drive <= n_flags.sounding;
            r_busy  <= n_flags.running;
        end
    end

    assign o_res.valid    = r_res_valid;
    assign o_res.drive    = r_drive;
    assign o_res.busy_res = r_busy;

endmodule

// File: sim/bps_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the beep pattern sequencer: watches the request and result
// channels, predicts each result and compares it. Depends on bps_pkg and bps_if.
module bps_result_checker
    import bps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bps_cmd_if   cmd_ch,
    bps_res_if   res_ch,
    output int   o_fail_count,
    output int   o_outstanding
);

    localparam int TIME_MAX  = 2 ** TIME_BITS_DEF - 1;
    localparam int COUNT_MAX = 2 ** COUNT_BITS_DEF - 1;

    // One predicted result: buzzer level and busy flag after a request.
    typedef struct packed {
        logic drive;
        logic busy_res;
    } t_buzz_level;

    t_buzz_level levels_due_q[$];
    int          mismatches = 0;

    // Predicted sequencer state.
    logic                      running;
    logic                      sounding;
    logic                      phase_is_on;
    logic [COUNT_BITS_DEF-1:0] tones_total;
    logic [COUNT_BITS_DEF-1:0] tones_done;
    logic [TIME_BITS_DEF-1:0]  phase_ticks;
    logic [TIME_BITS_DEF-1:0]  on_held;
    logic [TIME_BITS_DEF-1:0]  off_held;

    function automatic logic [TIME_BITS_DEF-1:0] sat_time(input logic [LEN_W-1:0] v);
        return (int'(v) > TIME_MAX) ? TIME_BITS_DEF'(TIME_MAX) : TIME_BITS_DEF'(v);
    endfunction

    function automatic logic [COUNT_BITS_DEF-1:0] sat_count(input logic [CNT_W-1:0] v);
        return (int'(v) > COUNT_MAX) ? COUNT_BITS_DEF'(COUNT_MAX) : COUNT_BITS_DEF'(v);
    endfunction

    function automatic void clear_buzzer();
        running     = 1'b0;
        sounding    = 1'b0;
        phase_is_on = 1'b0;
        tones_total = '0;
        tones_done  = '0;
        phase_ticks = '0;
        on_held     = '0;
        off_held    = '0;
    endfunction

    // A single tone is a pattern with no tone count; on_held carries its length.
    function automatic void start_tone(input logic [TIME_BITS_DEF-1:0] len);
        tones_total = '0;
        tones_done  = '0;
        phase_is_on = 1'b1;
        phase_ticks = '0;
        on_held     = len;
        sounding    = 1'b1;
        running     = 1'b1;
    endfunction

    // One millisecond passes: count it, then end the phase once its length is reached.
    function automatic void advance_ms();
        if (!running) return;
        if (phase_ticks != '1) phase_ticks++;
        if (tones_total == '0) begin
            if (phase_ticks >= on_held) begin
                sounding = 1'b0;
                running  = 1'b0;
            end
            return;
        end
        if (phase_is_on) begin
            if (phase_ticks >= on_held) begin
                sounding    = 1'b0;
                phase_is_on = 1'b0;
                phase_ticks = '0;
            end
        end else if (phase_ticks >= off_held) begin
            tones_done++;
            if (tones_done >= tones_total) begin
                running = 1'b0;
                return;
            end
            sounding    = 1'b1;
            phase_is_on = 1'b1;
            phase_ticks = '0;
        end
    endfunction

    function automatic void apply_request(input t_cmd op, input logic [LEN_W-1:0] beep_len,
                                          input logic [CNT_W-1:0] tones,
                                          input logic [LEN_W-1:0] on_len,
                                          input logic [LEN_W-1:0] off_len);
        logic [COUNT_BITS_DEF-1:0] n;
        n = sat_count(tones);
        case (op)
            CMD_TICK: begin
                advance_ms();
            end
            CMD_BEEP: begin
                start_tone(sat_time(beep_len));
            end
            CMD_PATTERN: begin
                // A pattern with no tones behaves as a beep of zero length.
                if (n == '0) begin
                    start_tone('0);
                end else begin
                    tones_total = n;
                    tones_done  = '0;
                    on_held     = sat_time(on_len);
                    off_held    = sat_time(off_len);
                    phase_is_on = 1'b1;
                    phase_ticks = '0;
                    sounding    = 1'b1;
                    running     = 1'b1;
                end
            end
            default: begin
                sounding = 1'b0;
                running  = 1'b0;
            end
        endcase
    endfunction

    // Compare each taken result with the oldest prediction, then predict new requests.
    always @(posedge i_clk) begin
        t_buzz_level due;
        if (!i_rst_n) begin
            clear_buzzer();
            levels_due_q.delete();
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (levels_due_q.size() == 0) begin
                    $error("result with no request pending: drive %0b, busy_res %0b",
                           res_ch.drive, res_ch.busy_res);
                    mismatches++;
                end else begin
                    due = levels_due_q.pop_front();
                    if (res_ch.drive !== due.drive) begin
                        $error("drive: expected %0b, actual %0b", due.drive, res_ch.drive);
                        mismatches++;
                    end
                    if (res_ch.busy_res !== due.busy_res) begin
                        $error("busy_res: expected %0b, actual %0b", due.busy_res,
                               res_ch.busy_res);
                        mismatches++;
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                apply_request(t_cmd'(cmd_ch.command), cmd_ch.beep_length, cmd_ch.tone_count,
                              cmd_ch.on_length, cmd_ch.off_length);
                levels_due_q.push_back('{drive: sounding, busy_res: running});
            end
        end
        o_outstanding <= levels_due_q.size();
        o_fail_count  <= mismatches;
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for beep_pattern_sequencer_core: drives requests and result stalls
// and gives the verdict. Depends on bps_pkg, bps_if and bps_result_checker.
module tb;
    import bps_pkg::*;

    localparam int QUIET_LIMIT     = 5000;
    localparam int ITEMS_PER_PHASE = 535;

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct  = 16;
    int   recv_stall_pct = 61;
    int   sent_count     = 0;
    int   quiet_cycles   = 0;
    int   fail_count;
    int   outstanding;

    bps_cmd_if cmd_ch ();
    bps_res_if res_ch ();

    beep_pattern_sequencer_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    bps_result_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .cmd_ch        (cmd_ch),
        .res_ch        (res_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random.
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // End the run when nothing is accepted for too long.
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("beep_pattern_sequencer_core: mismatch");
                $finish;
            end
        end
    end

    // Offer one request, idling first at random, and return at the next falling edge.
    task automatic push_cmd(input t_cmd op, input logic [LEN_W-1:0] beep_len,
                            input logic [CNT_W-1:0] tones, input logic [LEN_W-1:0] on_len,
                            input logic [LEN_W-1:0] off_len);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= op;
        cmd_ch.beep_length <= beep_len;
        cmd_ch.tone_count  <= tones;
        cmd_ch.on_length   <= on_len;
        cmd_ch.off_length  <= off_len;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        sent_count++;
        @(negedge i_clk);
    endtask

    // Ticks carry random values in the fields they do not use.
    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++) begin
            push_cmd(CMD_TICK, LEN_W'($urandom), CNT_W'($urandom), LEN_W'($urandom),
                     LEN_W'($urandom));
        end
    endtask

    // Mostly short lengths so that tones finish, now and then any value.
    function automatic logic [LEN_W-1:0] pick_len();
        if ($urandom_range(9, 0) < 8) return LEN_W'($urandom_range(6, 0));
        return LEN_W'($urandom);
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        if ($urandom_range(9, 0) < 8) return CNT_W'($urandom_range(4, 0));
        return CNT_W'($urandom);
    endfunction

    // Edge cases: idle ticks, zero and full lengths, empty patterns, restarts, stops.
    task automatic run_directed();
        send_ticks(1);
        push_cmd(CMD_BEEP, '0, '0, '0, '0);
        send_ticks(1);
        push_cmd(CMD_BEEP, 16'd2, '1, '1, '1);
        send_ticks(2);
        push_cmd(CMD_BEEP, '1, '0, '0, '0);
        send_ticks(1);
        push_cmd(CMD_STOP, '1, '1, '1, '1);
        push_cmd(CMD_STOP, '0, '0, '0, '0);
        push_cmd(CMD_PATTERN, '1, '0, '1, '1);
        send_ticks(1);
        push_cmd(CMD_PATTERN, '0, 8'd1, '0, '0);
        send_ticks(2);
        push_cmd(CMD_PATTERN, '0, 8'd2, 16'd1, 16'd2);
        send_ticks(6);
        push_cmd(CMD_PATTERN, '0, '1, '1, '1);
        push_cmd(CMD_BEEP, 16'd1, '0, '0, '0);
        push_cmd(CMD_PATTERN, '0, 8'd3, 16'd2, 16'd1);
        send_ticks(3);
        push_cmd(CMD_STOP, '0, '0, '0, '0);
    endtask

    // Mostly a start followed by enough ticks to finish it, the rest random requests.
    task automatic run_random(input int n_items);
        int                stop_at;
        int                pick;
        int                ticks_due;
        logic [LEN_W-1:0]  len_a;
        logic [LEN_W-1:0]  len_b;
        logic [CNT_W-1:0]  n;
        stop_at = sent_count + n_items;
        while (sent_count < stop_at) begin
            pick = $urandom_range(99, 0);
            if (pick < 30) begin
                push_cmd(t_cmd'($urandom_range(3, 0)), LEN_W'($urandom), CNT_W'($urandom),
                         LEN_W'($urandom), LEN_W'($urandom));
            end else begin
                if (pick < 60) begin
                    len_a = pick_len();
                    push_cmd(CMD_BEEP, len_a, CNT_W'($urandom), LEN_W'($urandom),
                             LEN_W'($urandom));
                    ticks_due = (len_a == '0) ? 1 : int'(len_a);
                end else begin
                    n     = pick_count();
                    len_a = pick_len();
                    len_b = pick_len();
                    push_cmd(CMD_PATTERN, LEN_W'($urandom), n, len_a, len_b);
                    ticks_due = (n == '0) ? 1 :
                        int'(n) * (((len_a == '0) ? 1 : int'(len_a)) +
                                   ((len_b == '0) ? 1 : int'(len_b)));
                end
                if (ticks_due > 60) ticks_due = 60;
                // Now and then cut the sequence short so the next start interrupts it.
                if ($urandom_range(9, 0) == 0) ticks_due = $urandom_range(ticks_due, 0);
                else ticks_due += $urandom_range(2, 0);
                send_ticks(ticks_due);
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.command     = CMD_TICK;
        cmd_ch.beep_length = '0;
        cmd_ch.tone_count  = '0;
        cmd_ch.on_length   = '0;
        cmd_ch.off_length  = '0;
        res_ch.ready       = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(ITEMS_PER_PHASE);
        send_idle_pct  = 61;
        recv_stall_pct = 16;
        run_random(ITEMS_PER_PHASE);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(ITEMS_PER_PHASE);
        cmd_ch.valid <= 1'b0;

        // Drain the remaining results, then wait for any stray ones before the verdict.
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("beep_pattern_sequencer_core: match");
        end else begin
            $display("beep_pattern_sequencer_core: mismatch");
        end
        $finish;
    end

endmodule

// File: beep_pattern_sequencer_core.f
rtl/core/bps_pkg.sv
rtl/core/bps_if.sv
rtl/core/bps_next.sv
rtl/core/beep_pattern_sequencer_core.sv
sim/bps_result_checker.sv
sim/tb.sv
